// ===== rtl/bdeq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
// Used by bdeq_ctrl, bdeq_dpath and bounded_double_ended_queue_top.
package bdeq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_POP_OUT,
      FSM_DUMP_RD,
      FSM_DUMP_OUT
   } fsm_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic                     last_of_run;
      status_type               status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       dump_clear;
      logic       dump_read;
      logic       load_out;
      logic       out_from_read;
      status_type out_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic rd_last;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on bdeq_pkg, bdeq_ctrl and bdeq_dpath.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one action and a value.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns results in order.
//   Push: one beat, status ok or full, registered and valid the cycle after accept.
//   Pop: one beat with the removed value (or status empty); the value passes
//     through the registered read of the ring store, then the output register.
//   Dump: one beat per stored entry front to back (or status empty), with
//     last_of_run on the final one; a read state and the registered read of
//     the ring store precede the first beat, then one beat per cycle while
//     the output register is free. The controller handles one item at a time;
//     the single read port of the ring store paces pops and dumps.
//   Unused action codes are taken and produce no beat.
//   A finished beat waits in the output register while rsp_stall is high; a
//   new push is taken as long as that register is free or drains this cycle.
//   Reset (synchronous, active high) empties the queue and drops any pending
//   beat; no clearing pass is needed.
module bounded_double_ended_queue_top
   import bdeq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   bdeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdeq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_data.value),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an item is only taken when the output register has room
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> sts.out_free)
      else $error("request accepted while output register is blocked");

   assert property (@(posedge clock) disable iff (reset)
      !(sts.empty && sts.full))
      else $error("queue reports empty and full together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.value_res == '0 && rsp_data.last_of_run))
      else $error("error beat carries data or is not last");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> !sts.full)
      else $error("write into a full queue");

endmodule

// ===== rtl/bdeq_ctrl.sv =====
// Controller state machine for the deque: decodes actions, sequences pops and dumps.
// Depends on bdeq_pkg; drives commands into bdeq_dpath.
module bdeq_ctrl
   import bdeq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_status = ST_OK;
      req_stall      = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               unique case (req_action) inside
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     cmd.load_out = 1'b1;
                     if (sts.full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.push_front = (req_action == ACT_PUSH_FRONT);
                        cmd.push_back  = (req_action == ACT_PUSH_BACK);
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     if (sts.empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.pop_front = (req_action == ACT_POP_FRONT);
                        cmd.pop_back  = (req_action == ACT_POP_BACK);
                        state_in      = FSM_POP_OUT;
                     end
                  end
                  ACT_DUMP: begin
                     if (sts.empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.dump_clear = 1'b1;
                        state_in       = FSM_DUMP_RD;
                     end
                  end
                  default: begin
                     // unused codes are consumed without a response
                  end
               endcase
            end
         end
         FSM_POP_OUT: begin
            if (sts.out_free) begin
               cmd.load_out      = 1'b1;
               cmd.out_from_read = 1'b1;
               state_in          = FSM_IDLE;
            end
         end
         FSM_DUMP_RD: begin
            cmd.dump_read = 1'b1;
            state_in      = FSM_DUMP_OUT;
         end
         FSM_DUMP_OUT: begin
            if (sts.out_free) begin
               cmd.load_out      = 1'b1;
               cmd.out_from_read = 1'b1;
               // prefetch the next entry while this one goes out
               if (sts.rd_last) begin
                  state_in = FSM_IDLE;
               end else begin
                  cmd.dump_read = 1'b1;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bdeq_dpath.sv =====
// Datapath for the deque: ring store, front pointer, count, dump index, output register.
// Depends on bdeq_pkg; commanded by bdeq_ctrl.
module bdeq_dpath
   import bdeq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] req_value,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic signed [DATA_W-1:0] mem [DEPTH];

   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] dump_idx_ff, dump_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rd_last_ff;
   rsp_type                  rsp_data_ff;

   logic [SW-1:0] sum_back_wr, sum_back_rd, sum_dump, sum_inc;
   logic [SW-1:0] pos_back_wr, pos_back_rd, pos_dump, pos_inc;
   logic [PW-1:0] front_dec;
   logic [PW-1:0] wr_addr, rd_addr;
   logic          wr_en, rd_en;
   logic          dump_last;
   logic          out_free;

   // ring positions: front + offset, folded once since the sum stays below 2*DEPTH
   always_comb begin
      sum_back_wr = SW'(front_ff) + SW'(count_ff);
      sum_back_rd = SW'(front_ff) + SW'(count_ff - CW'(1));
      sum_dump    = SW'(front_ff) + SW'(dump_idx_ff);
      sum_inc     = SW'(front_ff) + SW'(1);
      pos_back_wr = (sum_back_wr >= SW'(DEPTH)) ? sum_back_wr - SW'(DEPTH) : sum_back_wr;
      pos_back_rd = (sum_back_rd >= SW'(DEPTH)) ? sum_back_rd - SW'(DEPTH) : sum_back_rd;
      pos_dump    = (sum_dump >= SW'(DEPTH)) ? sum_dump - SW'(DEPTH) : sum_dump;
      pos_inc     = (sum_inc >= SW'(DEPTH)) ? sum_inc - SW'(DEPTH) : sum_inc;
      front_dec   = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - PW'(1);
   end

   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_dec : pos_back_wr[PW-1:0];
   assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.dump_read;
   assign rd_addr = cmd.pop_front ? front_ff :
                    cmd.pop_back  ? pos_back_rd[PW-1:0] : pos_dump[PW-1:0];

   assign dump_last = ((dump_idx_ff + CW'(1)) == count_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end
      if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_front) begin
         front_in = pos_inc[PW-1:0];
         count_in = count_ff - CW'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.dump_clear) begin
         dump_idx_in = '0;
      end else if (cmd.dump_read) begin
         dump_idx_in = dump_idx_ff + CW'(1);
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_last_ff <= cmd.dump_read ? dump_last : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.out_from_read) begin
            rsp_data_ff.value_res   <= rd_data_ff;
            rsp_data_ff.last_of_run <= rd_last_ff;
            rsp_data_ff.status      <= ST_OK;
         end else begin
            rsp_data_ff.value_res   <= '0;
            rsp_data_ff.last_of_run <= 1'b1;
            rsp_data_ff.status      <= cmd.out_status;
         end
      end
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CW'(DEPTH));
   assign sts.rd_last  = rd_last_ff;
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/bounded_double_ended_queue_top_test.sv =====
// Self-checking testbench for bounded_double_ended_queue_top: directed corner items, a
// backpressure fill, then random push/pop/dump traffic checked against a ring-store predictor.
// Depends on bdeq_pkg and the bounded_double_ended_queue_top RTL.
module bounded_double_ended_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bdeq_pkg::*;

   localparam int QDEPTH = DEPTH_DEFAULT;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bounded_double_ended_queue_top #(.DEPTH(QDEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predictor state: ring store, front slot, occupancy
   logic signed [DATA_W-1:0] ring_mem [QDEPTH];
   int front_ptr  = 0;
   int fill_count = 0;

   req_type queued_actions [$];
   rsp_type awaited_beats [$];

   int  send_idle_pct   = 31;
   int  recv_idle_pct   = 60;
   int  rsp_hold_cycles = 0;
   bit  req_fire        = 1'b0;
   int  items_queued    = 0;
   int  items_taken     = 0;
   int  beats_checked   = 0;
   int  mismatch_count  = 0;
   int  full_answers    = 0;
   int  empty_answers   = 0;
   int  dumps_seen      = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("bounded_double_ended_queue_top: mismatch");
      $finish;
   end

   // Work out the beats one accepted action produces and update the shadow deque.
   task automatic predict_deque_answer(input req_type item);
      rsp_type r;
      int      slot;
      r = '0;
      r.last_of_run = 1'b1;
      r.status = ST_OK;
      case (item.action) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (fill_count == QDEPTH) begin
               r.status = ST_FULL;
               full_answers++;
            end else begin
               if (item.action == ACT_PUSH_FRONT) begin
                  front_ptr = (front_ptr + QDEPTH - 1) % QDEPTH;
                  slot = front_ptr;
               end else begin
                  slot = (front_ptr + fill_count) % QDEPTH;
               end
               ring_mem[slot] = item.value;
               fill_count++;
            end
            awaited_beats.push_back(r);
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (fill_count == 0) begin
               r.status = ST_EMPTY;
               empty_answers++;
            end else if (item.action == ACT_POP_FRONT) begin
               r.value_res = ring_mem[front_ptr];
               front_ptr = (front_ptr + 1) % QDEPTH;
               fill_count--;
            end else begin
               r.value_res = ring_mem[(front_ptr + fill_count - 1) % QDEPTH];
               fill_count--;
            end
            awaited_beats.push_back(r);
         end
         ACT_DUMP: begin
            dumps_seen++;
            if (fill_count == 0) begin
               r.status = ST_EMPTY;
               empty_answers++;
               awaited_beats.push_back(r);
            end else begin
               for (int k = 0; k < fill_count; k++) begin
                  r.value_res = ring_mem[(front_ptr + k) % QDEPTH];
                  r.last_of_run = (k == fill_count - 1);
                  awaited_beats.push_back(r);
               end
            end
         end
         default: ; // unused codes are swallowed silently
      endcase
   endtask

   task automatic flag_mismatch(input bit has_want, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (has_want)
            $display("%t beat %0d: expected value %0d last %0b status %s,",
                     $realtime, beats_checked, want.value_res, want.last_of_run,
                     want.status.name(), " got value %0d last %0b status %s",
                     got.value_res, got.last_of_run, got.status.name());
         else
            $display("%t unexpected beat: value %0d last %0b status %0d",
                     $realtime, got.value_res, got.last_of_run, got.status);
      end
   endtask

   // Monitor: result beats are checked before the request taken on the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_beats.size() == 0) begin
               flag_mismatch(1'b0, '0, rsp_data);
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_data.value_res !== want.value_res ||
                   rsp_data.last_of_run !== want.last_of_run ||
                   rsp_data.status !== want.status)
                  flag_mismatch(1'b1, want, rsp_data);
            end
            beats_checked++;
         end
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            predict_deque_answer(req_data);
            items_taken++;
         end
      end
   end

   // Request driver: holds a beat until taken, then maybe idles before the next one.
   always @(negedge clock) begin
      logic    nxt_valid;
      req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         nxt_valid = 1'b0;
         if (queued_actions.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt_data  = queued_actions.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
   end

   // Result receiver: a long hold-off counts down here, otherwise random stalls.
   always @(negedge clock) begin
      logic nxt_stall;
      if (reset) begin
         nxt_stall = 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         nxt_stall = 1'b1;
         rsp_hold_cycles--;
      end else begin
         nxt_stall = ($urandom_range(99) < recv_idle_pct);
      end
      rsp_stall <= nxt_stall;
   end

   task automatic queue_action(input action_type act, input logic signed [DATA_W-1:0] val);
      req_type item;
      item.action = act;
      item.value  = val;
      queued_actions.push_back(item);
      items_queued++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return -32'sd1;
         3:       return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // mode 0 leans to pushes, 1 to pops, 2 is balanced
   task automatic queue_random_action(input int mode);
      int r;
      int push_pct;
      r = $urandom_range(99);
      push_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      if (r < 3)
         queue_action(action_type'($urandom_range(7, 5)), $urandom);
      else if (r < 10)
         queue_action(ACT_DUMP, $urandom);
      else if (r < 10 + push_pct)
         queue_action($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value());
      else
         queue_action($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || awaited_beats.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n += 20) begin
         int mode;
         mode = $urandom_range(2);
         for (int j = 0; j < 20; j++)
            queue_random_action(mode);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners on an empty deque, unused codes, extreme values, wrap of the front slot
      queue_action(ACT_POP_FRONT, 32'sd5);
      queue_action(ACT_POP_BACK, -32'sd5);
      queue_action(ACT_DUMP, 32'sd0);
      queue_action(action_type'(3'd5), 32'sh7fffffff);
      queue_action(action_type'(3'd6), 32'sh80000000);
      queue_action(action_type'(3'd7), -32'sd1);
      queue_action(ACT_PUSH_FRONT, 32'sh7fffffff);
      queue_action(ACT_PUSH_BACK, 32'sh80000000);
      queue_action(ACT_PUSH_FRONT, -32'sd1);
      queue_action(ACT_PUSH_BACK, 32'sd0);
      queue_action(ACT_DUMP, 32'sd0);
      queue_action(ACT_POP_BACK, 32'sd0);
      queue_action(ACT_POP_FRONT, 32'sd0);
      queue_action(ACT_POP_FRONT, 32'sd0);
      queue_action(ACT_POP_BACK, 32'sd0);
      queue_action(ACT_POP_BACK, 32'sd0);
      queue_action(ACT_DUMP, 32'sd0);
      wait_drained();

      // receiver holds off while pushes pile up: input stalls, deque fills, then overflows
      send_idle_pct = 0;
      @(negedge clock);
      rsp_hold_cycles = 150;
      for (int k = 0; k < QDEPTH + 2; k++)
         queue_action(ACT_PUSH_BACK, $urandom);
      queue_action(ACT_PUSH_FRONT, $urandom);
      queue_action(ACT_DUMP, 32'sd0);
      for (int k = 0; k < QDEPTH / 2; k++) begin
         queue_action(ACT_POP_FRONT, 32'sd0);
         queue_action(ACT_POP_BACK, 32'sd0);
      end
      queue_action(ACT_POP_FRONT, 32'sd0);
      wait_drained();

      send_idle_pct = 31;
      recv_idle_pct = 60;
      run_random(100);
      wait_drained();

      send_idle_pct = 60;
      recv_idle_pct = 31;
      run_random(100);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(100);
      wait_drained();

      repeat (QDEPTH + 8) @(posedge clock);
      if (awaited_beats.size() != 0)
         mismatch_count++;
      $display("Run covered %0d actions and %0d result beats, %0d dumps.",
               items_taken, beats_checked, dumps_seen);
      $display("Full answers: %0d, empty answers: %0d, mismatches: %0d.",
               full_answers, empty_answers, mismatch_count);
      if (mismatch_count == 0)
         $display("bounded_double_ended_queue_top: match");
      else
         $display("bounded_double_ended_queue_top: mismatch");
      $finish;
   end

endmodule
